/* src/sacr_pkg.sv */
package sacr_pkg;

	// Defaults for the top level parameters.
	localparam int DEF_WAYS         = 8;
	localparam int DEF_MAX_SET_BITS = 8;
	localparam int DEF_ADDR_BITS    = 32;

	// Fixed port widths.
	localparam int ADDR_W     = 32;
	localparam int WAY_OUT_W  = 3;
	localparam int COUNT_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Age ranks saturate instead of wrapping.
	localparam int              RANK_W   = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	// Random source.
	localparam int               LFSR_W    = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd2;

	// Replacement policy codes.
	localparam logic [2:0] POL_LRU  = 3'd0;
	localparam logic [2:0] POL_RAND = 3'd1;
	localparam logic [2:0] POL_FIFO = 3'd2;
	localparam logic [2:0] POL_MRU  = 3'd3;
	localparam logic [2:0] POL_NMRU = 3'd4;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_COLD  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	// Status of one lookup, handed from the policy logic to the top level.
	typedef struct packed {
		logic     hit;
		logic     evict;
		logic     lfsr_step;
		outcome_t outcome;
	} lookup_res_t;

	// One step of the Fibonacci LFSR, taps 16, 14, 13 and 11.
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
		logic fb;
		fb = s[0] ^ s[2] ^ s[3] ^ s[5];
		return {fb, s[LFSR_W-1:1]};
	endfunction

endpackage

/* src/set_assoc_cache_replacement_top.sv */
// Channel  Direction  Signals                                      Handshake
// request  in         start, busy, address                         start && !busy
// result   out        done, outcome, way_used, hit_total,          done, one cycle
//                     miss_total, eviction_total
// config   in         cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// One request is taken every cycle while busy is low. For an accepted request the set is
// read into an input register, the tag compare, victim choice and rank update run in one
// pass, and the result register follows, which shows the result with done high. A request
// to the set just written is served from a bypass register. After reset busy stays high
// while a clearing pass zeroes the valid, rank and recent-way stores one set a cycle;
// configuration writes are taken during that time. The result side cannot stall, so
// nothing ever holds off a request once the clearing pass is done.
module set_assoc_cache_replacement_top
	import sacr_pkg::*;
#(
	parameter int WAYS         = DEF_WAYS,
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [ADDR_W-1:0]     address,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [1:0]            outcome,
	output logic [WAY_OUT_W-1:0]  way_used,
	output logic [COUNT_W-1:0]    hit_total,
	output logic [COUNT_W-1:0]    miss_total,
	output logic [COUNT_W-1:0]    eviction_total
);

	// Only the low ADDR_BITS bits of the address take part, so the tag is never wider.
	localparam int TAG_W    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NUM_SETS = 2 ** MAX_SET_BITS;
	localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int SH_W     = 6;
	localparam logic [3:0]       SB_MAX   = 4'(MAX_SET_BITS);
	localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(NUM_SETS - 1);

	// The random pick is the LFSR value modulo WAYS. The quotient comes from a multiply by
	// a scaled reciprocal, exact for all 16-bit values, that is done one step ahead and
	// kept in a register, so only a constant multiply and a subtract remain in the lookup.
	localparam int RECIP_SH = LFSR_W + $clog2(WAYS);
	localparam int RECIP_W  = LFSR_W + 2;
	localparam int PROD_W   = LFSR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'(1) << RECIP_SH) / WAYS + 1);
	localparam logic [PROD_W-1:0]  PROD_RST =
		PROD_W'(lfsr_next(LFSR_SEED)) * PROD_W'(RECIP);
	localparam logic [LFSR_W-1:0]  WAYS_L   = LFSR_W'(WAYS);

	// Configuration registers.
	logic [3:0]  set_bits_q;
	logic [4:0]  block_bits_q;
	logic [2:0]  policy_q;

	// Clearing pass after reset.
	logic             clearing_q;
	logic [IDX_W-1:0] clr_idx_q;

	// Set stores.
	logic [WAYS-1:0]              valid_mem  [NUM_SETS];
	logic [WAYS-1:0][TAG_W-1:0]   tag_mem    [NUM_SETS];
	logic [WAYS-1:0][RANK_W-1:0]  rank_mem   [NUM_SETS];
	logic [WAY_W-1:0]             recent_mem [NUM_SETS];

	// Address split for the incoming request.
	logic             accept;
	logic [3:0]       sb_eff;
	logic [SH_W-1:0]  tag_sh;
	logic [TAG_W-1:0] addr_m;
	logic [TAG_W-1:0] blk_addr;
	logic [TAG_W-1:0] tag_in;
	logic [IDX_W-1:0] set_in;

	// Lookup stage.
	logic                         v_s1;
	logic [TAG_W-1:0]             tag_s1;
	logic [IDX_W-1:0]             set_s1;
	logic [WAYS-1:0]              rd_valid_s1;
	logic [WAYS-1:0][TAG_W-1:0]   rd_tags_s1;
	logic [WAYS-1:0][RANK_W-1:0]  rd_ranks_s1;
	logic [WAY_W-1:0]             rd_recent_s1;

	// Bypass of the set written at the last edge.
	logic                         fwd_v_q;
	logic [IDX_W-1:0]             fwd_set_q;
	logic [WAYS-1:0]              fwd_valid_q;
	logic [WAYS-1:0][TAG_W-1:0]   fwd_tags_q;
	logic [WAYS-1:0][RANK_W-1:0]  fwd_ranks_q;
	logic [WAY_W-1:0]             fwd_recent_q;

	logic                         use_fwd;
	logic [WAYS-1:0]              cur_valid;
	logic [WAYS-1:0][TAG_W-1:0]   cur_tags;
	logic [WAYS-1:0][RANK_W-1:0]  cur_ranks;
	logic [WAY_W-1:0]             cur_recent;

	logic [WAY_W-1:0]             sel_way;
	logic [WAYS-1:0]              valid_nx;
	logic [WAYS-1:0][TAG_W-1:0]   tags_nx;
	logic [WAYS-1:0][RANK_W-1:0]  ranks_nx;
	logic [WAY_W-1:0]             recent_nx;
	lookup_res_t                  res;

	// Random source.
	logic [LFSR_W-1:0] lfsr_q;
	logic [PROD_W-1:0] prod_q;
	logic [LFSR_W-1:0] lfsr_nx;
	logic [LFSR_W-1:0] quot;
	logic [LFSR_W-1:0] rem_raw;
	logic [LFSR_W-1:0] rem;
	logic [WAY_W-1:0]  pick;

	// Running counters, which are already the totals after the request shown on done.
	logic [COUNT_W-1:0] hit_cnt_q;
	logic [COUNT_W-1:0] miss_cnt_q;
	logic [COUNT_W-1:0] evict_cnt_q;

	// Result register.
	logic                 done_q;
	outcome_t             outcome_q;
	logic [WAY_OUT_W-1:0] way_used_q;

	assign busy      = clearing_q;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration writes. An index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			policy_q     <= POL_LRU;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data;
				CFG_POLICY:     policy_q     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Split the address. Set counts above the store size are clamped, and a shift that
	// runs past the top of the address leaves a zero tag.
	always_comb begin
		sb_eff   = (set_bits_q > SB_MAX) ? SB_MAX : set_bits_q;
		tag_sh   = SH_W'(sb_eff) + SH_W'(block_bits_q);
		addr_m   = address[TAG_W-1:0];
		tag_in   = addr_m >> tag_sh;
		blk_addr = addr_m >> block_bits_q;
		set_in   = blk_addr[IDX_W-1:0] & ~({IDX_W{1'b1}} << sb_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_SET) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Set stores: one write port, shared by the clearing pass and the lookup write-back,
	// and one registered read port used when a request is accepted.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			valid_mem[clr_idx_q]  <= '0;
			rank_mem[clr_idx_q]   <= '0;
			recent_mem[clr_idx_q] <= '0;
		end else if (v_s1) begin
			valid_mem[set_s1]  <= valid_nx;
			tag_mem[set_s1]    <= tags_nx;
			rank_mem[set_s1]   <= ranks_nx;
			recent_mem[set_s1] <= recent_nx;
		end
		if (accept) begin
			rd_valid_s1  <= valid_mem[set_in];
			rd_tags_s1   <= tag_mem[set_in];
			rd_ranks_s1  <= rank_mem[set_in];
			rd_recent_s1 <= recent_mem[set_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			v_s1    <= accept;
			fwd_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= tag_in;
			set_s1 <= set_in;
		end
		fwd_set_q    <= set_s1;
		fwd_valid_q  <= valid_nx;
		fwd_tags_q   <= tags_nx;
		fwd_ranks_q  <= ranks_nx;
		fwd_recent_q <= recent_nx;
	end

	// A request to the set written at the last edge read the store before that write
	// landed, so it takes the bypass copy instead.
	always_comb begin
		use_fwd = fwd_v_q && (fwd_set_q == set_s1);
		if (use_fwd) begin
			cur_valid  = fwd_valid_q;
			cur_tags   = fwd_tags_q;
			cur_ranks  = fwd_ranks_q;
			cur_recent = fwd_recent_q;
		end else begin
			cur_valid  = rd_valid_s1;
			cur_tags   = rd_tags_s1;
			cur_ranks  = rd_ranks_s1;
			cur_recent = rd_recent_s1;
		end
	end

	// Random pick: remainder of the next LFSR value, with one correction step as a guard.
	always_comb begin
		lfsr_nx = lfsr_next(lfsr_q);
		quot    = LFSR_W'(prod_q >> RECIP_SH);
		rem_raw = lfsr_nx - quot * WAYS_L;
		rem     = (rem_raw >= WAYS_L) ? rem_raw - WAYS_L : rem_raw;
		pick    = WAY_W'(rem);
	end

	sacr_policy #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W)
	) u_policy (
		.policy    (policy_q),
		.tag       (tag_s1),
		.valid     (cur_valid),
		.tags      (cur_tags),
		.ranks     (cur_ranks),
		.recent    (cur_recent),
		.pick      (pick),
		.way       (sel_way),
		.valid_nx  (valid_nx),
		.tags_nx   (tags_nx),
		.ranks_nx  (ranks_nx),
		.recent_nx (recent_nx),
		.res       (res)
	);

	// The LFSR steps only when a random victim is actually drawn. The product for the
	// value after the new one is formed here, ready for the next draw.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
			prod_q <= PROD_RST;
		end else if (v_s1 && res.lfsr_step) begin
			lfsr_q <= lfsr_nx;
			prod_q <= PROD_W'(lfsr_next(lfsr_nx)) * PROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (v_s1) begin
			if (res.hit) begin
				hit_cnt_q <= hit_cnt_q + COUNT_W'(1);
			end else begin
				miss_cnt_q <= miss_cnt_q + COUNT_W'(1);
			end
			if (res.evict) begin
				evict_cnt_q <= evict_cnt_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			outcome_q  <= res.outcome;
			way_used_q <= WAY_OUT_W'(sel_way);
		end
	end

	assign done           = done_q;
	assign outcome        = outcome_q;
	assign way_used       = way_used_q;
	assign hit_total      = hit_cnt_q;
	assign miss_total     = miss_cnt_q;
	assign eviction_total = evict_cnt_q;

endmodule

/* src/sacr_policy.sv */
module sacr_policy
	import sacr_pkg::*;
#(
	parameter int WAYS  = DEF_WAYS,
	parameter int TAG_W = DEF_ADDR_BITS
) (
	input  logic [2:0]                      policy,
	input  logic [TAG_W-1:0]                tag,
	input  logic [WAYS-1:0]                 valid,
	input  logic [WAYS-1:0][TAG_W-1:0]      tags,
	input  logic [WAYS-1:0][RANK_W-1:0]     ranks,
	input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] recent,
	input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] pick,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] way,
	output logic [WAYS-1:0]                 valid_nx,
	output logic [WAYS-1:0][TAG_W-1:0]      tags_nx,
	output logic [WAYS-1:0][RANK_W-1:0]     ranks_nx,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] recent_nx,
	output lookup_res_t                     res
);

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

	logic [2:0]        pol;
	logic              is_lru, is_fifo, is_mru, is_rand;
	logic              hit;
	logic [WAY_W-1:0]  hit_way;
	logic              any_inv;
	logic [WAY_W-1:0]  inv_way;
	logic [WAY_W-1:0]  old_way;
	logic [RANK_W-1:0] top_rank;
	logic              zero_found;
	logic [WAY_W-1:0]  nmru_way;
	logic [WAY_W-1:0]  miss_way;
	logic [RANK_W-1:0] old_rank;

	// Codes beyond the defined set fall back to LRU.
	always_comb begin
		pol = (policy > POL_NMRU) ? POL_LRU : policy;
		is_lru  = (pol == POL_LRU);
		is_fifo = (pol == POL_FIFO);
		is_mru  = (pol == POL_MRU) || (pol == POL_NMRU);
		is_rand = (pol == POL_RAND) || (pol == POL_NMRU);
	end

	// Lowest matching way wins, as does the lowest invalid way.
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		any_inv = 1'b0;
		inv_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (valid[i] && (tags[i] == tag)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(i);
			end
			if (!valid[i]) begin
				any_inv = 1'b1;
				inv_way = WAY_W'(i);
			end
		end
	end

	// Oldest way: the first unranked way, else the first way of highest rank.
	always_comb begin
		old_way    = '0;
		top_rank   = '0;
		zero_found = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!zero_found) begin
				if (ranks[i] == '0) begin
					old_way    = WAY_W'(i);
					zero_found = 1'b1;
				end else if (ranks[i] > top_rank) begin
					top_rank = ranks[i];
					old_way  = WAY_W'(i);
				end
			end
		end
	end

	always_comb begin
		nmru_way = pick;
		if ((pol == POL_NMRU) && (pick == recent)) begin
			nmru_way = (pick == LAST_WAY) ? '0 : pick + WAY_W'(1);
		end
		if (is_lru || is_fifo) begin
			miss_way = old_way;
		end else if (WAYS == 1) begin
			miss_way = '0;
		end else if (any_inv) begin
			miss_way = inv_way;
		end else if (pol == POL_MRU) begin
			miss_way = recent;
		end else begin
			miss_way = nmru_way;
		end
		way = hit ? hit_way : miss_way;
	end

	always_comb begin
		old_rank = ranks[way];
		ranks_nx = ranks;
		for (int i = 0; i < WAYS; i++) begin
			if (is_lru || (is_fifo && !hit)) begin
				if (way == WAY_W'(i)) begin
					ranks_nx[i] = RANK_W'(1);
				end else if ((ranks[i] != '0) &&
				             (is_fifo || (old_rank == '0) || (ranks[i] < old_rank))) begin
					ranks_nx[i] = (ranks[i] == RANK_MAX) ? RANK_MAX : ranks[i] + RANK_W'(1);
				end
			end
		end
	end

	always_comb begin
		valid_nx  = valid;
		tags_nx   = tags;
		recent_nx = is_mru ? way : recent;
		if (!hit) begin
			valid_nx[way] = 1'b1;
			tags_nx[way]  = tag;
		end
		res.hit       = hit;
		res.evict     = !hit && valid[way];
		res.lfsr_step = !hit && is_rand && (WAYS > 1) && !any_inv;
		if (hit) begin
			res.outcome = OUT_HIT;
		end else if (valid[way]) begin
			res.outcome = OUT_EVICT;
		end else begin
			res.outcome = OUT_COLD;
		end
	end

endmodule

/* tb/sv/sacr_lookup_checker.sv */
`timescale 1ns / 1ps

// Watches the request, configuration and result channels of the cache block. It keeps
// its own copy of the cache state and predicts every lookup when the request is taken.
module sacr_lookup_checker
	import sacr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [ADDR_W-1:0]     address,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  done,
	input  logic [1:0]            outcome,
	input  logic [WAY_OUT_W-1:0]  way_used,
	input  logic [COUNT_W-1:0]    hit_total,
	input  logic [COUNT_W-1:0]    miss_total,
	input  logic [COUNT_W-1:0]    eviction_total,
	output int                    mismatches,
	output int                    outstanding,
	output int                    lookups_checked
);

	localparam int NWAYS      = DEF_WAYS;
	localparam int NSETS      = 1 << DEF_MAX_SET_BITS;

	typedef struct packed {
		outcome_t             outcome;
		logic [WAY_OUT_W-1:0] way;
		logic [COUNT_W-1:0]   hits;
		logic [COUNT_W-1:0]   misses;
		logic [COUNT_W-1:0]   evictions;
	} lookup_t;

	logic                 line_valid [NSETS][NWAYS];
	logic [ADDR_W-1:0]    line_tag   [NSETS][NWAYS];
	logic [RANK_W-1:0]    line_rank  [NSETS][NWAYS];
	logic [WAY_OUT_W-1:0] mru_way    [NSETS];
	logic [LFSR_W-1:0]    lfsr;
	logic [COUNT_W-1:0]   hit_cnt, miss_cnt, evict_cnt;
	logic [3:0]           set_bits_q;
	logic [4:0]           block_bits_q;
	logic [2:0]           policy_q;
	lookup_t              pending_lookups [$];

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	function automatic logic [RANK_W-1:0] rank_up(input logic [RANK_W-1:0] r);
		return (r == RANK_MAX) ? RANK_MAX : r + 1'b1;
	endfunction

	// Ranks younger than the touched line age by one; a fresh line ages all ranked lines.
	function automatic void promote_lru(input int s, input int w);
		logic [RANK_W-1:0] old;
		old = line_rank[s][w];
		for (int i = 0; i < NWAYS; i++) begin
			if (i == w)
				line_rank[s][i] = 1;
			else if (line_rank[s][i] != 0 && (old == 0 || line_rank[s][i] < old))
				line_rank[s][i] = rank_up(line_rank[s][i]);
		end
	endfunction

	function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] a);
		int                sb, bb, s, w, best;
		logic [2:0]        pol;
		logic [63:0]       a64, tag, set_mask;
		logic [RANK_W-1:0] oldest_rank;
		lookup_t           r;
		sb = (set_bits_q > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(set_bits_q);
		bb = int'(block_bits_q);
		pol = (policy_q > POL_NMRU) ? POL_LRU : policy_q;
		a64 = {32'b0, a};
		tag = a64 >> (sb + bb);
		set_mask = (64'd1 << sb) - 64'd1;
		s = int'((a64 >> bb) & set_mask);

		w = -1;
		for (int i = 0; i < NWAYS; i++)
			if (w < 0 && line_valid[s][i] && line_tag[s][i] == tag[ADDR_W-1:0])
				w = i;

		if (w >= 0) begin
			hit_cnt++;
			r.outcome = OUT_HIT;
			if (pol == POL_LRU)
				promote_lru(s, w);
			else if (pol == POL_MRU || pol == POL_NMRU)
				mru_way[s] = WAY_OUT_W'(w);
		end else begin
			miss_cnt++;
			if (pol == POL_LRU || pol == POL_FIFO) begin
				// First unranked way wins, otherwise the first of the oldest.
				best = 0;
				oldest_rank = '0;
				for (int i = 0; i < NWAYS; i++) begin
					if (w < 0) begin
						if (line_rank[s][i] == 0) begin
							w = i;
						end else if (line_rank[s][i] > oldest_rank) begin
							oldest_rank = line_rank[s][i];
							best = i;
						end
					end
				end
				if (w < 0)
					w = best;
			end else if (NWAYS == 1) begin
				w = 0;
			end else begin
				for (int i = 0; i < NWAYS; i++)
					if (w < 0 && !line_valid[s][i])
						w = i;
				if (w < 0) begin
					if (pol == POL_MRU) begin
						w = int'(mru_way[s]) % NWAYS;
					end else begin
						lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
						w = int'(lfsr) % NWAYS;
						if (pol == POL_NMRU && w == int'(mru_way[s]))
							w = (w + 1) % NWAYS;
					end
				end
			end
			if (line_valid[s][w]) begin
				evict_cnt++;
				r.outcome = OUT_EVICT;
			end else begin
				r.outcome = OUT_COLD;
			end
			if (pol == POL_LRU) begin
				promote_lru(s, w);
			end else if (pol == POL_FIFO) begin
				for (int i = 0; i < NWAYS; i++) begin
					if (i == w)
						line_rank[s][i] = 1;
					else if (line_rank[s][i] != 0)
						line_rank[s][i] = rank_up(line_rank[s][i]);
				end
			end else if (pol == POL_MRU || pol == POL_NMRU) begin
				mru_way[s] = WAY_OUT_W'(w);
			end
			line_valid[s][w] = 1'b1;
			line_tag[s][w] = tag[ADDR_W-1:0];
		end

		r.way = WAY_OUT_W'(w);
		r.hits = hit_cnt;
		r.misses = miss_cnt;
		r.evictions = evict_cnt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			for (int s = 0; s < NSETS; s++) begin
				mru_way[s] = '0;
				for (int w = 0; w < NWAYS; w++) begin
					line_valid[s][w] = 1'b0;
					line_tag[s][w] = '0;
					line_rank[s][w] = '0;
				end
			end
			lfsr = LFSR_SEED;
			hit_cnt = '0;
			miss_cnt = '0;
			evict_cnt = '0;
			set_bits_q = '0;
			block_bits_q = '0;
			policy_q = POL_LRU;
			pending_lookups.delete();
			mismatches = 0;
			lookups_checked = 0;
			outstanding <= 0;
		end else begin
			if (done === 1'b1) begin
				if (pending_lookups.size() == 0) begin
					report_mismatch("result with no request pending", 64'd0, 64'(way_used));
				end else begin
					want = pending_lookups.pop_front();
					lookups_checked++;
					if (outcome !== want.outcome)
						report_mismatch("outcome", 64'(want.outcome), 64'(outcome));
					if (way_used !== want.way)
						report_mismatch("way_used", 64'(want.way), 64'(way_used));
					if (hit_total !== want.hits)
						report_mismatch("hit_total", 64'(want.hits), 64'(hit_total));
					if (miss_total !== want.misses)
						report_mismatch("miss_total", 64'(want.misses), 64'(miss_total));
					if (eviction_total !== want.evictions)
						report_mismatch("eviction_total", 64'(want.evictions),
							64'(eviction_total));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SET_BITS: begin
						set_bits_q = cfg_data[3:0];
					end
					CFG_BLOCK_BITS: begin
						block_bits_q = cfg_data;
					end
					CFG_POLICY: begin
						policy_q = cfg_data[2:0];
					end
					default: begin
					end
				endcase
			end
			if (start && !busy)
				pending_lookups.push_back(predict_lookup(address));
			outstanding <= pending_lookups.size();
		end
	end

endmodule

/* tb/sv/tb_set_assoc_cache_replacement_top.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the set-associative cache block. The run walks through a
// table of register settings. Each setting gets a burst of lookups whose addresses come
// mostly from a small pool of tags aimed at a few sets, so that sets fill up, hit and
// evict, with some fully random addresses mixed in. The checker beside the block does
// all prediction and comparison; this module only drives the ports and judges.
module tb_set_assoc_cache_replacement_top;
	import sacr_pkg::*;

	localparam int NPHASES       = 12;
	localparam int PHASE_ITEMS   = 32;
	localparam int TAG_POOL      = 12;
	// Extra settling after the last result comes back, so that the pipeline is empty.
	localparam int SETTLE_CYCLES = 4;
	// Far beyond the slowest legal run, clearing pass after reset included.
	localparam int CYCLE_LIMIT   = 200000;

	// The index past the last register writes nothing, and policy codes above NMRU
	// fall back to LRU. Both are exercised on purpose.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [2:0]           POL_ALT_5 = 3'd5;
	localparam logic [2:0]           POL_ALT_6 = 3'd6;
	localparam logic [2:0]           POL_ALT_7 = 3'd7;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic [ADDR_W-1:0]     address   = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  cfg_ready;
	logic                  done;
	logic [1:0]            outcome;
	logic [WAY_OUT_W-1:0]  way_used;
	logic [COUNT_W-1:0]    hit_total;
	logic [COUNT_W-1:0]    miss_total;
	logic [COUNT_W-1:0]    eviction_total;

	int mismatches;
	int outstanding;
	int lookups_checked;
	int items_sent = 0;
	int cycles     = 0;

	logic [ADDR_W-1:0] tag_pool [TAG_POOL];

	// Register settings per phase. The table covers every policy code, no set bits and
	// the largest count, an oversized set count that clamps, and block offsets from
	// zero up to the widest the register holds, where the tag has no bits left.
	logic [CFG_DATA_W-1:0] phase_sets   [NPHASES] = '{5'd1, 5'd0, 5'd3, 5'd2, 5'd1, 5'd8,
		5'd31, 5'd0, 5'd2, 5'd8, 5'd1, 5'd2};
	logic [CFG_DATA_W-1:0] phase_block  [NPHASES] = '{5'd4, 5'd0, 5'd5, 5'd2, 5'd3, 5'd23,
		5'd31, 5'd6, 5'd0, 5'd0, 5'd1, 5'd12};
	logic [2:0]            phase_policy [NPHASES] = '{POL_LRU, POL_RAND, POL_FIFO, POL_MRU,
		POL_NMRU, POL_LRU, POL_NMRU, POL_ALT_7, POL_FIFO, POL_ALT_5, POL_RAND, POL_ALT_6};
	// Sender idle chance in percent. Phases without idling give back-to-back stretches.
	int                    phase_idle   [NPHASES] = '{0, 65, 0, 26, 65, 0, 26, 0, 65, 26,
		0, 65};

	set_assoc_cache_replacement_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.address        (address),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.outcome        (outcome),
		.way_used       (way_used),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total)
	);

	sacr_lookup_checker lookup_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.address         (address),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.outcome         (outcome),
		.way_used        (way_used),
		.hit_total       (hit_total),
		.miss_total      (miss_total),
		.eviction_total  (eviction_total),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.lookups_checked (lookups_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. A lost result leaves the drain loop spinning, and it ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d lookups outstanding", cycles,
				outstanding);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one lookup request and holds it until the block takes it. start stays high
	// on return, so a caller that sends again right away keeps it high without a glitch.
	task automatic send_lookup(input logic [ADDR_W-1:0] a);
		start <= 1'b1;
		address <= a;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Stops offering requests and waits until every predicted result has come back, then
	// a few cycles more so that the pipeline is empty. The checker publishes its count
	// through a register, so the loop waits on the clock before it first reads the count.
	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Holds one register write until it is taken. cfg_valid is left high; the caller
	// lowers it after the last write of a group.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Most addresses reuse a pool of tags on the first few sets, so lines hit and get
	// evicted. Twelve in a hundred are fully random, and now and then the set is random too.
	function automatic logic [ADDR_W-1:0] pick_address(input int sb, input int bb);
		logic [63:0] a64, set_idx, set_mask, off;
		int          sbe;
		if ($urandom_range(0, 99) < 12)
			return $urandom();
		sbe = (sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sb;
		set_mask = (64'd1 << sbe) - 64'd1;
		set_idx = 64'($urandom_range(0, 3)) & set_mask;
		if ($urandom_range(0, 9) == 0)
			set_idx = 64'($urandom()) & set_mask;
		off = 64'($urandom()) & ((64'd1 << bb) - 64'd1);
		a64 = (64'(tag_pool[$urandom_range(0, TAG_POOL - 1)]) << (sbe + bb))
			| (set_idx << bb) | off;
		return a64[ADDR_W-1:0];
	endfunction

	initial begin
		int pause_at;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NPHASES; p++) begin
			// Registers only change while nothing is in flight.
			wait_for_results();
			write_register(CFG_SET_BITS, phase_sets[p]);
			write_register(CFG_BLOCK_BITS, phase_block[p]);
			// The spare bits above the policy code are don't-care; toggle them anyway.
			write_register(CFG_POLICY, {2'($urandom_range(0, 3)), phase_policy[p]});
			if (p == 3)
				write_register(CFG_SPARE, 5'($urandom()));
			cfg_valid <= 1'b0;

			for (int t = 0; t < TAG_POOL; t++)
				tag_pool[t] = $urandom();

			// Directed opening, with one set index bit and a 16-byte line. Address zero
			// and all ones land in different sets; zero and one share a line. Tags one
			// to nine then flood set zero past its eight ways, which forces evictions,
			// and the tail revisits a line that may or may not have survived.
			if (p == 0) begin
				send_lookup(32'h0000_0000);
				send_lookup(32'hFFFF_FFFF);
				send_lookup(32'h0000_0000);
				send_lookup(32'h8000_0000);
				send_lookup(32'h0000_0001);
				for (int t = 1; t <= 9; t++)
					send_lookup(ADDR_W'(t) << 5);
				send_lookup(ADDR_W'(3) << 5);
				send_lookup(32'h0000_0000);
				send_lookup(ADDR_W'(10) << 5);
				send_lookup(32'h7FFF_FFFF);
			end

			// Somewhere in every phase the sender stops until the block has caught up.
			pause_at = $urandom_range(4, PHASE_ITEMS - 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == pause_at)
					wait_for_results();
				send_lookup(pick_address(int'(phase_sets[p][3:0]), int'(phase_block[p])));
				if ($urandom_range(0, 99) < phase_idle[p]) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
			end
		end

		wait_for_results();
		$display("Sent %0d lookups and checked %0d results across %0d register settings.",
			items_sent, lookups_checked, NPHASES);
		$display("Every policy code ran, with set fills, evictions, idle gaps and drains.");
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
src/sacr_pkg.sv
src/sacr_policy.sv
src/set_assoc_cache_replacement_top.sv
tb/sv/sacr_lookup_checker.sv
tb/sv/tb_set_assoc_cache_replacement_top.sv
